// ===== src/tbpf_pkg.sv =====
// shared types and constants for the tile background pixel fetch block
// no dependencies; used by tbpf_vram and tile_background_pixel_fetch
`default_nettype none

package tbpf_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int ADDR_W     = $clog2(VRAM_BYTES);
    localparam int BANK_W     = ADDR_W - 1;
    localparam int BANK_DEPTH = VRAM_BYTES / 2;

    // configuration register indexes
    localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
    localparam logic [2:0] REG_SCROLL_X    = 3'd1;
    localparam logic [2:0] REG_SCROLL_Y    = 3'd2;
    localparam logic [2:0] REG_WINDOW_X    = 3'd3;
    localparam logic [2:0] REG_WINDOW_Y    = 3'd4;
    localparam logic [2:0] REG_BG_PALETTE  = 3'd5;

    localparam logic [7:0] LCD_CONTROL_RST = 8'd145;
    localparam logic [7:0] BG_PALETTE_RST  = 8'd252;
    localparam logic [7:0] WINDOW_X_SHIFT  = 8'd7;

    // lcd control bit positions
    localparam int LCDC_BG_EN     = 0;
    localparam int LCDC_BG_MAP    = 3;
    localparam int LCDC_TILE_MODE = 4;
    localparam int LCDC_WIN_EN    = 5;
    localparam int LCDC_WIN_MAP   = 6;

    // memory access request, split over even and odd byte banks
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en_even;
        logic              rd_en_odd;
        logic [BANK_W-1:0] rd_idx_even;
        logic [BANK_W-1:0] rd_idx_odd;
    } mem_req_t;

    typedef struct packed {
        logic [7:0] even;
        logic [7:0] odd;
    } mem_rsp_t;

    function automatic logic [7:0] gray_of_shade(input logic [1:0] shade);
        logic [7:0] g;
        case (shade)
            2'd0:    g = 8'd255;
            2'd1:    g = 8'd192;
            2'd2:    g = 8'd96;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== src/tile_background_pixel_fetch.sv =====
// tile background pixel fetch: write items fill video memory, render items give one pixel
// a render transfer issues the map read, ST_MAP issues the dependent tile row read of the
// same synchronous memory, and ST_ROW loads the result register once it is free
// writes enter while idle or as a render retires; a render blocks input during its map read
// reset: rst_n asynchronous active low; control, output valid and config registers reset,
// video memory contents are undefined until written
`default_nettype none

module tile_background_pixel_fetch (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [12:0] vram_addr,
    input  wire logic [7:0]  vram_data,
    input  wire logic [7:0]  pixel_col,
    input  wire logic [7:0]  scan_line,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             drawn,
    output logic [7:0]       out_col,
    output logic [7:0]       out_line,
    output logic [1:0]       color_index,
    output logic [1:0]       shade,
    output logic [7:0]       gray_level,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import tbpf_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a transfer
    localparam logic [1:0] ST_MAP  = 2'd1;  // map byte arriving from memory
    localparam logic [1:0] ST_ROW  = 2'd2;  // tile row bytes arriving from memory

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [7:0] lcd_control_reg;
    logic [7:0] scroll_x_reg;
    logic [7:0] scroll_y_reg;
    logic [7:0] window_x_reg;
    logic [7:0] window_y_reg;
    logic [7:0] bg_palette_reg;

    // per-render context carried across the memory reads
    logic [7:0] col_reg;
    logic [7:0] line_reg;
    logic [2:0] ox_lo_reg;
    logic [2:0] oy_lo_reg;
    logic       map_bank_reg;

    // result register
    logic       out_valid_reg;
    logic       drawn_reg;
    logic [7:0] out_col_reg;
    logic [7:0] out_line_reg;
    logic [1:0] color_reg;
    logic [1:0] shade_reg;
    logic [7:0] gray_reg;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    logic       out_free;
    logic       in_xfer;
    logic       render_xfer;

    // render address path
    logic [7:0]        wx0;
    logic              in_window;
    logic              map_sel;
    logic [7:0]        ox;
    logic [7:0]        oy;
    logic [ADDR_W-1:0] map_addr;

    // tile row path
    logic [7:0]        tile_idx;
    logic              row_high;
    logic [BANK_W-1:0] row_idx;

    // color path
    logic [2:0] bit_sel;
    logic [1:0] color;
    logic [1:0] pal_shade;

    tbpf_vram u_vram (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    assign cfg_ready = 1'b1;

    // the result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    // a new item may enter while idle, or while the previous render retires
    assign in_ready    = (state_reg == ST_IDLE) || ((state_reg == ST_ROW) && out_free);
    assign in_xfer     = in_valid && in_ready;
    assign render_xfer = in_xfer && mode;

    // window or scrolled background selection
    always_comb
    begin
        wx0       = window_x_reg - WINDOW_X_SHIFT;
        in_window = lcd_control_reg[LCDC_WIN_EN] && (pixel_col >= wx0)
                    && (scan_line >= window_y_reg);
        if (in_window)
        begin
            map_sel = lcd_control_reg[LCDC_WIN_MAP];
            ox      = pixel_col - wx0;
            oy      = scan_line - window_y_reg;
        end
        else
        begin
            map_sel = lcd_control_reg[LCDC_BG_MAP];
            ox      = pixel_col + scroll_x_reg;
            oy      = scan_line + scroll_y_reg;
        end
        // map base 0x1800 or 0x1c00, 32 tiles per map row
        map_addr = {2'b11, map_sel, oy[7:3], ox[7:3]};
    end

    // tile row address is always even: low byte in the even bank, high byte in the odd bank
    // signed mode places index 0..127 at 0x1000 and 128..255 at 0x0800
    always_comb
    begin
        tile_idx = map_bank_reg ? mem_rsp.odd : mem_rsp.even;
        row_high = !lcd_control_reg[LCDC_TILE_MODE] && !tile_idx[7];
        row_idx  = {row_high, tile_idx, oy_lo_reg};
    end

    // pixel color from the two row bytes, msb is the leftmost pixel
    always_comb
    begin
        bit_sel   = ~ox_lo_reg;
        color     = {mem_rsp.odd[bit_sel], mem_rsp.even[bit_sel]};
        pal_shade = bg_palette_reg[{color, 1'b0} +: 2];
    end

    // memory requests: writes and map reads at the input transfer, row reads after the map
    always_comb
    begin
        mem_req             = '0;
        mem_req.wr_en       = in_xfer && !mode;
        mem_req.wr_addr     = vram_addr;
        mem_req.wr_data     = vram_data;
        if (state_reg == ST_MAP)
        begin
            mem_req.rd_en_even  = 1'b1;
            mem_req.rd_en_odd   = 1'b1;
            mem_req.rd_idx_even = row_idx;
            mem_req.rd_idx_odd  = row_idx;
        end
        else if (render_xfer)
        begin
            mem_req.rd_en_even  = !map_addr[0];
            mem_req.rd_en_odd   = map_addr[0];
            mem_req.rd_idx_even = map_addr[ADDR_W-1:1];
            mem_req.rd_idx_odd  = map_addr[ADDR_W-1:1];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (render_xfer)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                // hold here while the result register is stalled
                if (out_free)
                begin
                    state_next = render_xfer ? ST_MAP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_control_reg <= LCD_CONTROL_RST;
            scroll_x_reg    <= '0;
            scroll_y_reg    <= '0;
            window_x_reg    <= '0;
            window_y_reg    <= '0;
            bg_palette_reg  <= BG_PALETTE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LCD_CONTROL: lcd_control_reg <= cfg_data;
                REG_SCROLL_X:    scroll_x_reg    <= cfg_data;
                REG_SCROLL_Y:    scroll_y_reg    <= cfg_data;
                REG_WINDOW_X:    window_x_reg    <= cfg_data;
                REG_WINDOW_Y:    window_y_reg    <= cfg_data;
                REG_BG_PALETTE:  bg_palette_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // render context, captured at the render transfer
    always_ff @(posedge clk)
    begin
        if (render_xfer)
        begin
            col_reg      <= pixel_col;
            line_reg     <= scan_line;
            ox_lo_reg    <= ox[2:0];
            oy_lo_reg    <= oy[2:0];
            map_bank_reg <= map_addr[0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_ROW && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROW && out_free)
        begin
            drawn_reg    <= lcd_control_reg[LCDC_BG_EN];
            out_col_reg  <= col_reg;
            out_line_reg <= line_reg;
            color_reg    <= color;
            shade_reg    <= pal_shade;
            gray_reg     <= gray_of_shade(pal_shade);
        end
    end

    assign out_valid   = out_valid_reg;
    assign drawn       = drawn_reg;
    assign out_col     = out_col_reg;
    assign out_line    = out_line_reg;
    assign color_index = color_reg;
    assign shade       = shade_reg;
    assign gray_level  = gray_reg;

endmodule

`default_nettype wire

// ===== src/tbpf_vram.sv =====
// video memory: two byte banks (even and odd addresses), one read port each
// depends on tbpf_pkg for the request type and sizes
`default_nettype none

module tbpf_vram (
    input  wire logic               clk,
    input  wire tbpf_pkg::mem_req_t req,
    output tbpf_pkg::mem_rsp_t      rsp
);
    import tbpf_pkg::*;

    logic [7:0] bank_even [BANK_DEPTH];
    logic [7:0] bank_odd  [BANK_DEPTH];

    // writes go to the bank picked by address bit 0
    always_ff @(posedge clk)
    begin
        if (req.wr_en && !req.wr_addr[0])
        begin
            bank_even[req.wr_addr[ADDR_W-1:1]] <= req.wr_data;
        end
        if (req.wr_en && req.wr_addr[0])
        begin
            bank_odd[req.wr_addr[ADDR_W-1:1]] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en_even)
        begin
            rsp.even <= bank_even[req.rd_idx_even];
        end
        if (req.rd_en_odd)
        begin
            rsp.odd <= bank_odd[req.rd_idx_odd];
        end
    end

endmodule

`default_nettype wire

// ===== src/tbpf_checker.sv =====
// port-level checks for tile_background_pixel_fetch, attached by bind
// no package dependency; sees the top-level ports only
`default_nettype none

module tbpf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        mode,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  shade,
    input wire logic [7:0]  gray_level
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a render keeps the input side closed during its map read
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> !in_ready)
        else $error("input taken during map read");

    // a render is followed by a raised out_valid once its map and row reads are through
    a_render_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> ##2 out_valid)
        else $error("render produced no result");

    // gray level follows the shade
    a_gray_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shade == 2'd0 && gray_level == 8'd255)
                   || (shade == 2'd1 && gray_level == 8'd192)
                   || (shade == 2'd2 && gray_level == 8'd96)
                   || (shade == 2'd3 && gray_level == 8'd0))
        else $error("gray level does not match shade");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (.*);

`default_nettype wire
